// ----- src/sktt_pkg.sv -----
// shared types and constants for the sorted key/value toggle table
// used by sktt_ctrl, sktt_dp and sorted_key_value_toggle_table_unit
`default_nettype none

package sktt_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // item kinds
    localparam logic OP_TOGGLE = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result codes
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the incoming item
        logic compare;  // register per-cell compare flags
        logic update;   // shift cells, write result, adjust count
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/sktt_dp.sv -----
// datapath: row of sorted key/value cells, compare flags, count and result payload
// depends on sktt_pkg
`default_nettype none

module sktt_dp #(
    parameter int CAPACITY = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire sktt_pkg::cmd_t               cmd,
    input  wire logic                         op,
    input  wire logic [sktt_pkg::KEY_W-1:0]   key_in,
    input  wire logic [sktt_pkg::VAL_W-1:0]   value_in,
    output logic      [sktt_pkg::STATUS_W-1:0] status,
    output logic      [sktt_pkg::VAL_W-1:0]   value_out,
    output logic      [sktt_pkg::COUNT_W-1:0] count_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                         op_reg;
    logic [sktt_pkg::KEY_W-1:0]   key_reg;
    logic [sktt_pkg::VAL_W-1:0]   val_reg;

    logic [sktt_pkg::KEY_W-1:0]   key_cells [CAPACITY];
    logic [sktt_pkg::VAL_W-1:0]   val_cells [CAPACITY];

    logic [CAPACITY-1:0]          lt_reg;
    logic [CAPACITY-1:0]          eq_reg;
    logic [CAPACITY-1:0]          at_pos;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [sktt_pkg::STATUS_W-1:0] status_reg;
    logic [sktt_pkg::STATUS_W-1:0] status_next;
    logic [sktt_pkg::VAL_W-1:0]   vout_reg;
    logic [sktt_pkg::VAL_W-1:0]   vout_next;

    logic                         hit;
    logic                         full;
    logic                         do_ins;
    logic                         do_rm;
    logic [sktt_pkg::VAL_W-1:0]   vsel;
    logic [CW+sktt_pkg::COUNT_W-1:0] count_wide;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            key_reg <= key_in;
            val_reg <= value_in;
        end
    end

    assign hit    = |eq_reg;
    assign full   = (count_reg == CW'(CAPACITY));
    assign do_rm  = (op_reg == sktt_pkg::OP_TOGGLE) && hit;
    assign do_ins = (op_reg == sktt_pkg::OP_TOGGLE) && !hit && !full;

    // data of the matching cell, at most one flag is set
    always_comb
    begin
        vsel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eq_reg[i])
            begin
                vsel = vsel | val_cells[i];
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : gen_cell
            logic occupied;

            assign occupied = (count_reg > CW'(g));

            // first cell whose key is not below the item key
            if (g == 0)
            begin : gen_pos_first
                assign at_pos[g] = !lt_reg[g];
            end
            else
            begin : gen_pos_rest
                assign at_pos[g] = !lt_reg[g] && lt_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (cmd.compare)
                begin
                    lt_reg[g] <= occupied && ($signed(key_cells[g]) < $signed(key_reg));
                    eq_reg[g] <= occupied && (key_cells[g] == key_reg);
                end
            end

            always_ff @(posedge clk)
            begin
                if (cmd.update && do_ins && !lt_reg[g])
                begin
                    if (at_pos[g])
                    begin
                        key_cells[g] <= key_reg;
                        val_cells[g] <= val_reg;
                    end
                    else
                    begin
                        key_cells[g] <= key_cells[(g == 0) ? 0 : g-1];
                        val_cells[g] <= val_cells[(g == 0) ? 0 : g-1];
                    end
                end
                else if (cmd.update && do_rm && !lt_reg[g] && (g < CAPACITY-1))
                begin
                    // cells above the count pick up junk, never read
                    key_cells[g] <= key_cells[(g < CAPACITY-1) ? g+1 : g];
                    val_cells[g] <= val_cells[(g < CAPACITY-1) ? g+1 : g];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        vout_next   = '0;
        status_next = sktt_pkg::ST_NOT_FOUND;
        if (op_reg == sktt_pkg::OP_LOOKUP)
        begin
            if (hit)
            begin
                status_next = sktt_pkg::ST_FOUND;
                vout_next   = vsel;
            end
        end
        else if (hit)
        begin
            status_next = sktt_pkg::ST_REMOVED;
            count_next  = count_reg - CW'(1);
        end
        else if (full)
        begin
            status_next = sktt_pkg::ST_FULL;
        end
        else
        begin
            status_next = sktt_pkg::ST_INSERTED;
            count_next  = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.update)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            status_reg <= status_next;
            vout_reg   <= vout_next;
        end
    end

    // low count bits, zero-extended when the count is narrow
    assign count_wide = {{sktt_pkg::COUNT_W{1'b0}}, count_reg};
    assign count_out  = count_wide[sktt_pkg::COUNT_W-1:0];
    assign status     = status_reg;
    assign value_out  = vout_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $onehot0(eq_reg))
        else $error("more than one cell matches the key");

    a_full_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && full && !hit && op_reg == sktt_pkg::OP_TOGGLE)
            |=> (status_reg == sktt_pkg::ST_FULL) && $stable(count_reg))
        else $error("insert into full table changed the count");

endmodule

`default_nettype wire

// ----- src/sktt_ctrl.sv -----
// controller: item sequencing and result handshake for the toggle table
// depends on sktt_pkg
`default_nettype none

module sktt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output sktt_pkg::cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;

    // a new item may enter during the update cycle of the previous one
    assign s_tready    = (state_reg == S_IDLE) || ((state_reg == S_UPD) && out_free);
    assign cmd.load    = s_tvalid && s_tready;
    assign cmd.compare = (state_reg == S_CMP);
    assign cmd.update  = (state_reg == S_UPD) && out_free;
    assign m_tvalid    = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    state_next = cmd.load ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cmp_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |=> (state_reg == S_UPD))
        else $error("compare not followed by update");

    a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> m_tvalid)
        else $error("update without result");

    a_no_load_in_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> !s_tready)
        else $error("item taken during compare");

endmodule

`default_nettype wire

// ----- src/sorted_key_value_toggle_table_unit.sv -----
// top level of the sorted key/value toggle table
// depends on sktt_pkg, sktt_ctrl and sktt_dp
//
// Usage: items enter on the s_ channel (s_tuser = op, s_tdata = key, value),
// each gives one result on the m_ channel (m_tuser = status, m_tdata = value,
// count). A toggle removes a present key or inserts an absent one at its
// sorted place unless the table is full; a lookup reports presence and data.
// All cells compare against the key at once and the flags are registered;
// the shift and result write follow in the update step, which waits until
// the output register frees up. A new item may be taken in the update step
// of the previous one. The compare row and the shift row hold CAPACITY cells.
// Reset empties the table (count zero) and drops any pending result; the
// cells themselves are not cleared and need no clearing pass.
// While the receiver stalls, the finished result waits in the output
// register; the next item is taken and compared, then waits in its update
// step until the output register frees up.
`default_nettype none

module sorted_key_value_toggle_table_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] key_in, [63:32] value_in
    input  wire logic [0:0]  s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] value_out, [38:32] count_out, [39] zero
    output logic [2:0]       m_tuser    // [2:0] status
);

    sktt_pkg::cmd_t                    cmd;
    logic [sktt_pkg::VAL_W-1:0]        value_out;
    logic [sktt_pkg::COUNT_W-1:0]      count_out;

    sktt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sktt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op        (s_tuser[0]),
        .key_in    (s_tdata[31:0]),
        .value_in  (s_tdata[63:32]),
        .status    (m_tuser),
        .value_out (value_out),
        .count_out (count_out)
    );

    assign m_tdata = {1'b0, count_out, value_out};

endmodule

`default_nettype wire
